// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the allocator RTL.
// Define NO_ASSERTIONS to compile every assertion away.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// The consequent must hold in the same cycle as the antecedent.
`define BFA_ASSERT_IMPLY(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("bfa: same-cycle assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define BFA_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("bfa: next-cycle assertion failed");

`else

`define BFA_ASSERT_IMPLY(name, clk, rst, ante, cons)
`define BFA_ASSERT_NEXT(name, clk, rst, ante, cons)

`endif

`endif

// ===== rtl/bfa_pkg.sv =====
// Shared types and constants for the best-fit arena allocator.
// No dependencies; every RTL module refers to this package by scoped names.
`timescale 1ns / 1ps

package bfa_pkg;

   typedef logic [31:0] word_type;

   // Register file: four start registers followed by four end registers.
   localparam int unsigned RegCount = 8;
   localparam int unsigned RegIdxW  = 3;
   localparam int unsigned AddrW    = 5;
   localparam int unsigned RegPools = 4;

   localparam logic [RegIdxW-1:0] REG_POOL0_START = 3'd0;
   localparam logic [RegIdxW-1:0] REG_POOL0_END   = 3'd4;

   localparam word_type StartReset [RegPools] = '{
      32'd2148363664, 32'd2151534592, 32'd2149900800, 32'd2155639184
   };
   localparam word_type EndReset [RegPools] = '{
      32'd2149423104, 32'd2151534592, 32'd2149900800, 32'd2155872256
   };

   // Request modes.
   localparam logic [1:0] MODE_FRONT = 2'd0;
   localparam logic [1:0] MODE_PEEK  = 2'd1;
   localparam logic [1:0] MODE_BACK  = 2'd2;
   localparam logic [1:0] MODE_NAMED = 2'd3;

   typedef struct packed {
      logic [1:0] mode;
      word_type   request_size;
      logic [1:0] pool_select;
   } req_type;

   typedef struct packed {
      word_type   block_address;
      logic       no_space;
      logic [1:0] pool_used;
   } rsp_type;

   // Pointer reload request from the register file, one strobe per pool.
   typedef struct packed {
      logic [RegPools-1:0]                load;
      logic [RegPools-1:0][31:0]          start_addr;
      logic [RegPools-1:0][31:0]          end_addr;
   } pool_load_type;

endpackage

// ===== rtl/bfa_csr.sv =====
// Configuration register file of the allocator with its APB-style slave port.
// Depends on bfa_pkg; raises a reload strobe for the pool a write touches.
`timescale 1ns / 1ps

module bfa_csr (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_psel,
   input  logic                         csr_penable,
   input  logic                         csr_pwrite,
   input  logic [bfa_pkg::AddrW-1:0]    csr_paddr,
   input  bfa_pkg::word_type            csr_pwdata,
   output bfa_pkg::word_type            csr_prdata,
   output logic                         csr_pready,
   output bfa_pkg::pool_load_type       pool_load
);

   logic [bfa_pkg::RegCount-1:0][31:0] regs_ff;
   logic [bfa_pkg::RegCount-1:0][31:0] regs_in;
   logic [bfa_pkg::RegIdxW-1:0]        reg_idx;
   logic                               wr_en;

   assign csr_pready = 1'b1;
   assign reg_idx    = csr_paddr[bfa_pkg::AddrW-1:2];
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;
   assign csr_prdata = regs_ff[reg_idx];

   always_comb begin
      regs_in = regs_ff;
      for (int r = 0; r < bfa_pkg::RegCount; r++) begin
         if (wr_en && (reg_idx == bfa_pkg::RegIdxW'(r))) begin
            regs_in[r] = csr_pwdata;
         end
      end
   end

   // A write to either register of a pool reloads both of its live pointers
   // from the freshly written register values.
   always_comb begin
      for (int k = 0; k < bfa_pkg::RegPools; k++) begin
         pool_load.load[k] = wr_en && (reg_idx[1:0] == 2'(k));
         pool_load.start_addr[k] = regs_in[int'(bfa_pkg::REG_POOL0_START) + k];
         pool_load.end_addr[k]   = regs_in[int'(bfa_pkg::REG_POOL0_END) + k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < bfa_pkg::RegPools; k++) begin
            regs_ff[int'(bfa_pkg::REG_POOL0_START) + k] <= bfa_pkg::StartReset[k];
            regs_ff[int'(bfa_pkg::REG_POOL0_END) + k]   <= bfa_pkg::EndReset[k];
         end
      end else begin
         regs_ff <= regs_in;
      end
   end

endmodule

// ===== rtl/bfa_pick.sv =====
// Best-fit pool choice: free space per pool, the ranking sort and the winner.
// Depends on bfa_pkg; purely combinational, fed from the pointer registers.
`timescale 1ns / 1ps

module bfa_pick #(
   parameter int POOL_COUNT = 4
) (
   input  logic [POOL_COUNT-1:0][31:0] front_addr,
   input  logic [POOL_COUNT-1:0][31:0] back_addr,
   input  bfa_pkg::word_type           request_size,
   output logic [POOL_COUNT-1:0]       choice,
   output logic                        found
);

   localparam int IdxW = (POOL_COUNT > 1) ? $clog2(POOL_COUNT) : 1;

   logic [POOL_COUNT-1:0][31:0]           free_bytes;
   logic [POOL_COUNT-1:0]                 fits;
   logic [POOL_COUNT-1:0][POOL_COUNT-1:0] not_less;
   logic [POOL_COUNT-1:0][IdxW-1:0]       order;
   logic [IdxW-1:0]                       spare;
   logic [IdxW-1:0]                       winner;
   logic                                  hit;

   // Every pair of pools is compared once, in parallel. The ranking then
   // replays a bubble sort that swaps on greater-or-equal, moving pool
   // indices only, so pools of equal free space end up in exactly the order
   // that such a sort leaves them. The best fit is the first ranked pool that
   // fits; the fallback is the last ranked pool, which has the most room.
   always_comb begin
      spare = '0;
      for (int k = 0; k < POOL_COUNT; k++) begin
         free_bytes[k] = back_addr[k] - front_addr[k];
         fits[k]       = request_size < free_bytes[k];
         order[k]      = IdxW'(k);
      end
      for (int a = 0; a < POOL_COUNT; a++) begin
         for (int b = 0; b < POOL_COUNT; b++) begin
            not_less[a][b] = free_bytes[a] >= free_bytes[b];
         end
      end
      for (int i = POOL_COUNT - 1; i > 0; i--) begin
         for (int j = 0; j < i; j++) begin
            if (not_less[order[j]][order[j + 1]]) begin
               spare        = order[j];
               order[j]     = order[j + 1];
               order[j + 1] = spare;
            end
         end
      end
      hit    = 1'b0;
      winner = order[POOL_COUNT - 1];
      for (int i = 0; i < POOL_COUNT; i++) begin
         if (!hit && fits[order[i]]) begin
            winner = order[i];
            hit    = 1'b1;
         end
      end
      found = hit;
      for (int k = 0; k < POOL_COUNT; k++) begin
         choice[k] = (winner == IdxW'(k));
      end
   end

endmodule

// ===== rtl/best_fit_arena_bump_allocator.sv =====
// Best-fit bump arena allocator: an accepted request beat waits in the input register and
// its response in the result register; one request is taken every cycle unless both fill.
// Throughput is set by the single compute stage between the input and result registers.
// Synchronous active-high reset empties both registers and reloads the config registers and
// the live pointers with their reset values at once; no clearing pass follows.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module best_fit_arena_bump_allocator #(
   parameter int POOL_COUNT = 4
) (
   input  logic                      clock,
   input  logic                      reset,
   // Request channel.
   input  logic                      req_valid,
   output logic                      req_ready,
   input  bfa_pkg::req_type          req_payload,
   // Response channel.
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output bfa_pkg::rsp_type          rsp_payload,
   // Configuration port.
   input  logic                      csr_psel,
   input  logic                      csr_penable,
   input  logic                      csr_pwrite,
   input  logic [bfa_pkg::AddrW-1:0] csr_paddr,
   input  bfa_pkg::word_type         csr_pwdata,
   output bfa_pkg::word_type         csr_prdata,
   output logic                      csr_pready
);

   // Input register: holds a request beat until the compute stage takes it.
   logic             in_vld_ff, in_vld_in;
   bfa_pkg::req_type in_data_ff, in_data_in;

   // Result register: holds a response beat until the consumer takes it.
   logic             rsp_vld_ff, rsp_vld_in;
   bfa_pkg::rsp_type rsp_data_ff, rsp_data_in;

   // Live pool pointers.
   logic [POOL_COUNT-1:0][31:0] front_ff, front_in;
   logic [POOL_COUNT-1:0][31:0] back_ff, back_in;

   bfa_pkg::pool_load_type pool_load;

   logic                  advance;
   logic                  take;
   logic [POOL_COUNT-1:0] pick_oh;
   logic                  fit_found;
   logic [POOL_COUNT-1:0] sel_oh;
   logic [POOL_COUNT-1:0] pool_oh;
   bfa_pkg::word_type     front_cur;
   bfa_pkg::word_type     back_cur;
   bfa_pkg::word_type     round_size;
   bfa_pkg::word_type     front_next;
   bfa_pkg::word_type     back_next;
   logic                  move_front;
   logic                  move_back;
   bfa_pkg::rsp_type      result;

   bfa_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .pool_load   (pool_load)
   );

   bfa_pick #(
      .POOL_COUNT (POOL_COUNT)
   ) u_pick (
      .front_addr   (front_ff),
      .back_addr    (back_ff),
      .request_size (in_data_ff.request_size),
      .choice       (pick_oh),
      .found        (fit_found)
   );

   // The held request moves on whenever the result register is empty or is
   // being emptied in this cycle. A new beat is accepted whenever the input
   // register is empty or its request moves on, even while a finished response still waits.
   assign advance   = in_vld_ff && (!rsp_vld_ff || rsp_ready);
   assign req_ready = !in_vld_ff || advance;
   assign take      = req_valid && req_ready;

   assign rsp_valid   = rsp_vld_ff;
   assign rsp_payload = rsp_data_ff;

   // A named pool beyond the last one saturates to the last pool.
   always_comb begin
      for (int k = 0; k < POOL_COUNT; k++) begin
         sel_oh[k] = (int'(in_data_ff.pool_select) == k) ||
                     ((k == POOL_COUNT - 1) &&
                      (int'(in_data_ff.pool_select) >= POOL_COUNT));
      end
   end

   // Compute stage: choose a pool, read its pointers, form the response and
   // the moved pointer. Sizes round up to 16 bytes with 32-bit wrap.
   always_comb begin
      pool_oh    = (in_data_ff.mode == bfa_pkg::MODE_NAMED) ? sel_oh : pick_oh;
      front_cur  = '0;
      back_cur   = '0;
      result     = '0;
      for (int k = 0; k < POOL_COUNT; k++) begin
         if (pool_oh[k]) begin
            front_cur          = front_cur | front_ff[k];
            back_cur           = back_cur | back_ff[k];
            result.pool_used   = result.pool_used | 2'(k);
         end
      end
      round_size = (in_data_ff.request_size + 32'd15) & ~32'd15;
      front_next = front_cur + round_size;
      back_next  = back_cur - round_size;
      move_front = 1'b0;
      move_back  = 1'b0;
      unique case (in_data_ff.mode) inside
         bfa_pkg::MODE_FRONT, bfa_pkg::MODE_NAMED: begin
            result.block_address = front_cur;
            move_front           = 1'b1;
         end
         bfa_pkg::MODE_PEEK: begin
            result.block_address = front_cur;
         end
         bfa_pkg::MODE_BACK: begin
            if (fit_found) begin
               result.block_address = back_next;
               move_back            = 1'b1;
            end else begin
               result.block_address = '0;
               result.no_space      = 1'b1;
            end
         end
      endcase
   end

   // Pointer update. A configuration write reloads both pointers of its pool;
   // pools without registers are only ever moved by allocations.
   always_comb begin
      front_in = front_ff;
      back_in  = back_ff;
      for (int k = 0; k < POOL_COUNT; k++) begin
         if (advance && pool_oh[k] && move_front) begin
            front_in[k] = front_next;
         end
         if (advance && pool_oh[k] && move_back) begin
            back_in[k] = back_next;
         end
         if ((k < bfa_pkg::RegPools) && pool_load.load[2'(k)]) begin
            front_in[k] = pool_load.start_addr[2'(k)];
            back_in[k]  = pool_load.end_addr[2'(k)];
         end
      end
   end

   always_comb begin
      in_vld_in   = take || (in_vld_ff && !advance);
      in_data_in  = take ? req_payload : in_data_ff;
      rsp_vld_in  = advance || (rsp_vld_ff && !rsp_ready);
      rsp_data_in = advance ? result : rsp_data_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff  <= 1'b0;
         rsp_vld_ff <= 1'b0;
         for (int k = 0; k < POOL_COUNT; k++) begin
            front_ff[k] <= (k < bfa_pkg::RegPools) ? bfa_pkg::StartReset[2'(k)] : '0;
            back_ff[k]  <= (k < bfa_pkg::RegPools) ? bfa_pkg::EndReset[2'(k)] : '0;
         end
      end else begin
         in_vld_ff  <= in_vld_in;
         rsp_vld_ff <= rsp_vld_in;
         front_ff   <= front_in;
         back_ff    <= back_in;
      end
   end

   always_ff @(posedge clock) begin
      in_data_ff  <= in_data_in;
      rsp_data_ff <= rsp_data_in;
   end

   // The ranking is a total order, so exactly one pool is always chosen.
   `BFA_ASSERT_IMPLY(a_pick_onehot, clock, reset, 1'b1, $onehot(pick_oh))

   // A back allocation that finds no room leaves every back pointer alone.
   `BFA_ASSERT_NEXT(a_nospace_keeps_back, clock, reset, advance && (in_data_ff.mode == bfa_pkg::MODE_BACK) && !fit_found && !(|pool_load.load), $stable(back_ff))

   // Requests are only held off while both registers are occupied.
   `BFA_ASSERT_IMPLY(a_ready_low_full, clock, reset, !req_ready, in_vld_ff && rsp_vld_ff)

   // A request that leaves the input register always produces a response.
   `BFA_ASSERT_NEXT(a_advance_gives_rsp, clock, reset, advance, rsp_vld_ff)

endmodule

// ===== tb/tb_top.sv =====
// Self-checking testbench for best_fit_arena_bump_allocator.
// Depends on bfa_pkg for the request and response beat types, the mode codes
// and the register reset values; needs nothing but the RTL to build.
`timescale 1ns / 1ps

module tb_top;
   import bfa_pkg::*;

   localparam int POOLS          = 4;
   localparam int CLOCK_HALF     = 4;
   localparam int RESET_CYCLES   = 10;
   localparam int MAX_GAP        = 12;
   localparam int LONG_HOLD      = 120;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int PHASE_ITEMS    = 93;

   // Pool layouts applied between phases.
   localparam int LAYOUT_EMPTY = 0;   // every pointer at zero
   localparam int LAYOUT_TOP   = 1;   // every pointer at all ones
   localparam int LAYOUT_WIDE  = 2;   // start zero, end all ones
   localparam int LAYOUT_SMALL = 3;   // short random spans
   localparam int LAYOUT_MIXED = 4;   // spans, wrapped spans and empty pools
   localparam int LAYOUT_KEEP  = 5;   // reload a single pool, others drift on

   logic     clock;
   logic     reset = 1'b1;

   logic     req_valid = 1'b0;
   logic     req_ready;
   req_type  req_payload = '0;
   logic     rsp_valid;
   logic     rsp_ready = 1'b0;
   rsp_type  rsp_payload;

   logic             csr_psel    = 1'b0;
   logic             csr_penable = 1'b0;
   logic             csr_pwrite  = 1'b0;
   logic [AddrW-1:0] csr_paddr   = '0;
   word_type         csr_pwdata  = '0;
   word_type         csr_prdata;
   logic             csr_pready;

   // Shadow of the register file and of the live pool pointers.
   word_type pool_regs  [RegCount];
   word_type pool_front [POOLS];
   word_type pool_back  [POOLS];

   req_type  pending_requests [$];
   rsp_type  expected_grants  [$];

   bit steady_flow = 1'b0;   // no idling on either side while set
   int holds_asked = 0;      // bumped to ask the receiver for a long hold-off
   int mismatch_count = 0;

   best_fit_arena_bump_allocator #(
      .POOL_COUNT(POOLS)
   ) u_top (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #CLOCK_HALF clock = ~clock;
   end

   // A register write stores the value and reloads both live pointers of the
   // pool that the register belongs to, from its start and end registers.
   function automatic void note_register_write(input logic [RegIdxW-1:0] idx,
                                               input word_type value);
      int k;
      k = idx % RegPools;
      pool_regs[idx] = value;
      if (k < POOLS) begin
         pool_front[k] = pool_regs[REG_POOL0_START + k];
         pool_back[k]  = pool_regs[REG_POOL0_END + k];
      end
   endfunction

   // Works out the grant for one request and applies its pointer update.
   // The pools are ranked by free space with a bubble sort that swaps on equal
   // as well, so pools of equal space keep whatever order those swaps leave.
   function automatic rsp_type predict_allocation(input req_type rq);
      rsp_type  grant;
      word_type avail [POOLS];
      int       rank [POOLS];
      word_type step;
      int       pick, slot, tmp;
      bit       fits;
      grant = '0;
      // Rounding up to 16 wraps to zero for sizes above 0xFFFFFFF0.
      step  = (rq.request_size + 32'd15) & 32'hFFFF_FFF0;
      if (rq.mode == MODE_NAMED) begin
         slot = (rq.pool_select >= POOLS) ? POOLS - 1 : int'(rq.pool_select);
         grant.block_address = pool_front[slot];
         pool_front[slot] = pool_front[slot] + step;
      end else begin
         for (int i = 0; i < POOLS; i++) begin
            rank[i]  = i;
            avail[i] = pool_back[i] - pool_front[i];
         end
         for (int i = POOLS - 1; i > 0; i--) begin
            for (int j = 0; j < i; j++) begin
               if (avail[rank[j]] >= avail[rank[j + 1]]) begin
                  tmp = rank[j];
                  rank[j] = rank[j + 1];
                  rank[j + 1] = tmp;
               end
            end
         end
         // With no pool big enough, the largest one (last in rank) is taken.
         pick = POOLS - 1;
         fits = 1'b0;
         for (int i = 0; i < POOLS; i++) begin
            if (!fits && rq.request_size < avail[rank[i]]) begin
               pick = i;
               fits = 1'b1;
            end
         end
         slot = rank[pick];
         case (rq.mode)
            MODE_FRONT: begin
               grant.block_address = pool_front[slot];
               pool_front[slot] = pool_front[slot] + step;
            end
            MODE_PEEK: begin
               grant.block_address = pool_front[slot];
            end
            default: begin
               if (fits) begin
                  pool_back[slot] = pool_back[slot] - step;
                  grant.block_address = pool_back[slot];
               end else begin
                  grant.no_space = 1'b1;
               end
            end
         endcase
      end
      grant.pool_used = slot[1:0];
      return grant;
   endfunction

   // Request driver. The payload is held while the beat waits for ready; after
   // each beat it idles for the gap that was drawn when the beat went out.
   int send_gap = 0;

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         send_gap  <= 0;
      end else if (!req_valid || req_ready) begin
         if (send_gap > 0) begin
            req_valid <= 1'b0;
            send_gap  <= send_gap - 1;
         end else if (pending_requests.size() != 0) begin
            req_payload <= pending_requests.pop_front();
            req_valid   <= 1'b1;
            send_gap    <= steady_flow ? 0 : $urandom_range(0, MAX_GAP);
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Response sink. It stalls for a freshly drawn number of cycles after each
   // beat it takes, and drops ready for a long stretch whenever one is asked for,
   // so that the block backs up and holds off the request side.
   int sink_stall = 0;
   int hold_left  = 0;
   int holds_seen = 0;

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready  <= 1'b0;
         sink_stall = 0;
         hold_left  = 0;
      end else if (holds_seen != holds_asked) begin
         holds_seen = holds_asked;
         hold_left  = LONG_HOLD;
         rsp_ready  <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left = hold_left - 1;
         rsp_ready <= 1'b0;
      end else if (rsp_valid && rsp_ready) begin
         sink_stall = steady_flow ? 0 : $urandom_range(0, MAX_GAP);
         rsp_ready  <= (sink_stall == 0);
      end else if (sink_stall > 0) begin
         sink_stall = sink_stall - 1;
         rsp_ready  <= (sink_stall == 0);
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // Monitor: checks every response beat against the oldest prediction, logs a
   // prediction for every request beat taken, and watches for a hung block.
   int quiet_cycles = 0;

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         quiet_cycles = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_grants.size() == 0) begin
               $error("response beat with nothing outstanding: block_address %h",
                      rsp_payload.block_address);
               mismatch_count++;
            end else begin
               want = expected_grants.pop_front();
               if (rsp_payload.block_address !== want.block_address) begin
                  $error("block_address: expected %h, actual %h",
                         want.block_address, rsp_payload.block_address);
                  mismatch_count++;
               end
               if (rsp_payload.no_space !== want.no_space) begin
                  $error("no_space: expected %b, actual %b",
                         want.no_space, rsp_payload.no_space);
                  mismatch_count++;
               end
               if (rsp_payload.pool_used !== want.pool_used) begin
                  $error("pool_used: expected %0d, actual %0d",
                         want.pool_used, rsp_payload.pool_used);
                  mismatch_count++;
               end
            end
         end
         if (req_valid && req_ready)
            expected_grants.push_back(predict_allocation(req_payload));
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("TEST FAILED");
            $finish;
         end
      end
   end

   // One register write: a setup phase, then an access phase held until pready.
   task automatic csr_write(input logic [RegIdxW-1:0] idx, input word_type value);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      note_register_write(idx, value);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   task automatic program_pools(input int layout);
      word_type lo, hi;
      if (layout == LAYOUT_KEEP) begin
         // Reloading one pool puts its pointers back to the stored addresses.
         if ($urandom_range(0, 1))
            csr_write(REG_POOL0_START + 3'($urandom_range(0, RegPools - 1)),
                      $urandom & 32'hFFFF_FFF0);
         else
            csr_write(REG_POOL0_END + 3'($urandom_range(0, RegPools - 1)), $urandom);
      end else begin
         for (int k = 0; k < RegPools; k++) begin
            case (layout)
               LAYOUT_EMPTY: begin lo = '0;  hi = '0; end
               LAYOUT_TOP:   begin lo = '1;  hi = '1; end
               LAYOUT_WIDE:  begin lo = '0;  hi = '1; end
               LAYOUT_SMALL: begin
                  lo = $urandom & 32'hFFFF_FFF0;
                  hi = lo + $urandom_range(0, 16384);
               end
               default: begin
                  lo = $urandom & 32'hFFFF_FFF0;
                  case ($urandom_range(0, 3))
                     0:       hi = lo;
                     1:       hi = lo - $urandom_range(1, 4096);
                     2:       hi = $urandom;
                     default: hi = lo + $urandom_range(0, 1 << 20);
                  endcase
               end
            endcase
            if ($urandom_range(0, 1)) begin
               csr_write(REG_POOL0_START + 3'(k), lo);
               csr_write(REG_POOL0_END + 3'(k), hi);
            end else begin
               csr_write(REG_POOL0_END + 3'(k), hi);
               csr_write(REG_POOL0_START + 3'(k), lo);
            end
         end
      end
   endtask

   task automatic queue_request(input logic [1:0] mode, input word_type size,
                                input logic [1:0] sel);
      req_type rq;
      rq.mode         = mode;
      rq.request_size = size;
      rq.pool_select  = sel;
      pending_requests.push_back(rq);
   endtask

   // Mostly small sizes so that pools fill and run out within a phase, with a
   // share of full-width values and sizes close to the rounding wrap.
   function automatic word_type random_size();
      int unsigned pick;
      pick = $urandom_range(0, 99);
      if (pick < 55)
         return $urandom_range(0, 4095);
      else if (pick < 75)
         return $urandom_range(0, 1 << 18);
      else if (pick < 85)
         return $urandom;
      else if (pick < 92)
         return 32'hFFFF_FFFF - $urandom_range(0, 40);
      else
         return $urandom_range(0, 255) << 4;
   endfunction

   // The sender stays quiet until the block has answered everything.
   task automatic wait_drained();
      do @(negedge clock);
      while (pending_requests.size() != 0 || req_valid || expected_grants.size() != 0);
   endtask

   int phase_layout [] = '{LAYOUT_SMALL, LAYOUT_EMPTY, LAYOUT_SMALL, LAYOUT_TOP,
                           LAYOUT_WIDE, LAYOUT_MIXED, LAYOUT_KEEP, LAYOUT_SMALL,
                           LAYOUT_MIXED, LAYOUT_KEEP, LAYOUT_SMALL};

   initial begin
      for (int k = 0; k < RegPools; k++) begin
         pool_regs[REG_POOL0_START + k] = StartReset[k];
         pool_regs[REG_POOL0_END + k]   = EndReset[k];
         pool_front[k] = StartReset[k];
         pool_back[k]  = EndReset[k];
      end
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed part on the reset layout, where two pools are empty and tie.
      queue_request(MODE_PEEK,  32'd0, 2'd0);
      queue_request(MODE_FRONT, 32'd0, 2'd3);
      queue_request(MODE_FRONT, 32'd1, 2'd1);
      queue_request(MODE_FRONT, 32'd16, 2'd2);
      queue_request(MODE_FRONT, 32'd17, 2'd0);
      queue_request(MODE_BACK,  32'd100, 2'd3);
      // Nothing fits: back allocation reports no space, the others take the
      // largest pool, and sizes past 0xFFFFFFF0 round to a zero step.
      queue_request(MODE_BACK,  32'hFFFF_FFFF, 2'd0);
      queue_request(MODE_PEEK,  32'hFFFF_FFFF, 2'd1);
      queue_request(MODE_FRONT, 32'hFFFF_FFFF, 2'd2);
      queue_request(MODE_FRONT, 32'hFFFF_FFF1, 2'd3);
      queue_request(MODE_BACK,  32'hFFFF_FFF0, 2'd0);
      // Overrunning the largest pool leaves it with wrapped, huge free space.
      queue_request(MODE_FRONT, 32'd2000000, 2'd0);
      queue_request(MODE_PEEK,  32'd5, 2'd1);
      queue_request(MODE_BACK,  32'd0, 2'd2);
      queue_request(MODE_NAMED, 32'h10, 2'd0);
      queue_request(MODE_NAMED, 32'hFFFF_FFFF, 2'd1);
      queue_request(MODE_NAMED, 32'h7FFF_FFFF, 2'd2);
      queue_request(MODE_NAMED, 32'd33, 2'd3);
      queue_request(MODE_FRONT, 32'd233071, 2'd1);
      queue_request(MODE_BACK,  32'h8000_0000, 2'd2);
      queue_request(MODE_PEEK,  32'd1, 2'd3);
      queue_request(MODE_FRONT, 32'd15, 2'd2);
      wait_drained();

      foreach (phase_layout[p]) begin
         steady_flow = (p == 2 || p == 7);
         program_pools(phase_layout[p]);
         @(negedge clock);
         // Back the block up while the sender keeps offering beats.
         if (p == 4 || p == 8)
            holds_asked++;
         for (int n = 0; n < PHASE_ITEMS; n++)
            queue_request(2'($urandom_range(0, 3)), random_size(),
                          2'($urandom_range(0, 3)));
         wait_drained();
      end

      repeat (4) @(posedge clock);
      if (mismatch_count == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule
